// File: rtl/crcdf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame deframer.
// No dependencies; imported by every module of the block.
package crcdf_pkg;

  localparam logic [7:0]  SYNC_LO         = 8'h55;
  localparam logic [7:0]  SYNC_HI         = 8'hAA;
  localparam logic [15:0] CRC_SEED        = 16'hFFFF;
  localparam logic [2:0]  HDR_LAST        = 3'd5;   // six header bytes, 0..5
  localparam int          MAX_PAYLOAD_DEF = 1024;
  localparam int          NUM_TYPES       = 256;
  localparam int          CNT_W           = 32;

  typedef enum logic [2:0] {
    PH_SYNC0,
    PH_SYNC1,
    PH_HDR,
    PH_PAYLOAD,
    PH_CRC
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic [7:0]       addr;
    logic [CNT_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [9:0]       byte_index;
    logic [7:0]       frame_type;
    logic [7:0]       frame_flags;
    logic [15:0]      sequence_res;
    logic [10:0]      payload_length;
    logic [15:0]      received_crc;
    logic [15:0]      computed_crc;
    logic [CNT_W-1:0] total_crc_errors;
    logic [CNT_W-1:0] type_crc_errors;
  } res_t;

  // Reflected CRC-16 (0x1021 reflected), one byte per call.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] e;
    logic [7:0] f;
    begin
      e = crc[7:0] ^ b;
      f = e ^ {e[3:0], 4'h0};
      crc_byte = {8'h00, crc[15:8]} ^ {f, 8'h00} ^ {5'b0, f, 3'b0} ^ {12'h000, f[7:4]};
    end
  endfunction

endpackage

// File: rtl/crcdf_err_store.sv
// Per-type CRC error count store: 256 x 32 synchronous RAM with registered read.
// Valid bits give the cleared value after reset. Depends on crcdf_pkg.
module crcdf_err_store
  import crcdf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  rd_req_t          rd,
  input  wr_req_t          wr,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0]     mem [NUM_TYPES];
  logic [NUM_TYPES-1:0] vld;
  logic [CNT_W-1:0]     mem_q;
  logic                 vld_q;
  logic                 fwd_q;
  logic [CNT_W-1:0]     fwd_data_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mem_q      <= mem[rd.addr];
      fwd_data_q <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        vld_q <= vld[rd.addr];
        fwd_q <= wr.en && (wr.addr == rd.addr);  // same-entry write bypass
      end
    end
  end

  assign rd_data = fwd_q ? fwd_data_q : (vld_q ? mem_q : '0);

endmodule

// File: rtl/crc16_frame_deframer.sv
// Top level of the sync/header/payload/CRC-16 frame deframer.
// Depends on crcdf_pkg and crcdf_err_store.
//
// Takes one received byte per beat and hunts for the sync pair 0x55 0xAA
// (a repeated 0x55 keeps waiting for 0xAA). It then gathers a six-byte
// header (type, flags, little-endian length, little-endian sequence), passes
// each payload byte on as a result beat as it arrives, and checks the
// little-endian CRC trailer against the reflected CRC-16 (seed 0xFFFF, no
// final xor) over header and payload. The second trailer byte yields one
// frame-end beat marked good or bad. A length above MAX_PAYLOAD silently
// restarts the hunt. Bad frames bump a 32-bit wrapping total and a 32-bit
// wrapping count for the frame type; the per-type counts live in a 256 x 32
// synchronous RAM, read when the type byte arrives and written back at a bad
// frame end. Reset clears the counts at once through per-entry valid bits,
// so no clearing pass follows reset. The block takes one byte per cycle
// while rx_stall is low; each byte's parse and CRC update is combinational
// and its result is registered in the output register, or in the one-beat
// skid stage while the output is stalled. The skid stage keeps input taking
// bytes while a result waits; rx_stall rises only when both are full.
module crc16_frame_deframer
  import crcdf_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // receive channel
  input  logic             rx_valid,
  output logic             rx_stall,
  input  logic [7:0]       rx_byte,
  // result channel
  output logic             res_valid,
  input  logic             res_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [9:0]       byte_index,
  output logic [7:0]       frame_type,
  output logic [7:0]       frame_flags,
  output logic [15:0]      sequence_res,
  output logic [10:0]      payload_length,
  output logic [15:0]      received_crc,
  output logic [15:0]      computed_crc,
  output logic [CNT_W-1:0] total_crc_errors,
  output logic [CNT_W-1:0] type_crc_errors
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  // parser state
  phase_t           phase, phase_next;
  logic [47:0]      hdr, hdr_next;
  logic [2:0]       hdr_cnt, hdr_cnt_next;
  logic [LEN_W-1:0] flen, flen_next;
  logic [LEN_W-1:0] pcnt, pcnt_next;
  logic [7:0]       trl_lo, trl_lo_next;
  logic             trl_cnt, trl_cnt_next;
  logic [15:0]      crc, crc_next;
  logic [CNT_W-1:0] err_total, err_total_next;
  logic [CNT_W-1:0] type_cnt, type_cnt_next;
  logic             cnt_load;   // store read data lands this cycle

  // count store ports
  rd_req_t          st_rd;
  wr_req_t          st_wr;
  logic [CNT_W-1:0] st_rd_data;

  // result path
  logic             acc;
  logic             res_new;
  res_t             res;
  res_t             out_q, skid_q;
  logic             out_v, skid_v;
  logic             out_fire;

  logic [15:0]      len;
  logic [15:0]      rx_crc;
  logic [LEN_W-1:0] pcnt_inc;
  logic [15:0]      flen16;
  logic [15:0]      pcnt16;

  assign acc      = rx_valid && !rx_stall;
  assign rx_stall = skid_v;
  assign out_fire = out_v && !res_stall;

  // length bytes are header bytes 2 and 3, already held when the last one arrives
  assign len      = hdr[31:16];
  assign rx_crc   = {rx_byte, trl_lo};
  assign pcnt_inc = pcnt + LEN_W'(1);
  assign flen16   = 16'(flen);
  assign pcnt16   = 16'(pcnt);

  crcdf_err_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd      (st_rd),
    .wr      (st_wr),
    .rd_data (st_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SYNC0;
      hdr       <= '0;
      hdr_cnt   <= '0;
      flen      <= '0;
      pcnt      <= '0;
      trl_lo    <= '0;
      trl_cnt   <= 1'b0;
      crc       <= CRC_SEED;
      err_total <= '0;
      type_cnt  <= '0;
      cnt_load  <= 1'b0;
    end else begin
      phase     <= phase_next;
      hdr       <= hdr_next;
      hdr_cnt   <= hdr_cnt_next;
      flen      <= flen_next;
      pcnt      <= pcnt_next;
      trl_lo    <= trl_lo_next;
      trl_cnt   <= trl_cnt_next;
      crc       <= crc_next;
      err_total <= err_total_next;
      type_cnt  <= type_cnt_next;
      cnt_load  <= st_rd.en;
    end
  end

  // Parser: next state, store accesses and the result beat.
  always_comb begin
    phase_next     = phase;
    hdr_next       = hdr;
    hdr_cnt_next   = hdr_cnt;
    flen_next      = flen;
    pcnt_next      = pcnt;
    trl_lo_next    = trl_lo;
    trl_cnt_next   = trl_cnt;
    crc_next       = crc;
    err_total_next = err_total;
    type_cnt_next  = cnt_load ? st_rd_data : type_cnt;
    st_rd          = '0;
    st_wr          = '0;
    res_new        = 1'b0;
    res            = '0;
    res.kind       = KIND_PAYLOAD;

    if (acc) begin
      case (phase)
        PH_SYNC0: begin
          if (rx_byte == SYNC_LO) phase_next = PH_SYNC1;
        end
        PH_SYNC1: begin
          if (rx_byte == SYNC_HI) begin
            phase_next   = PH_HDR;
            hdr_cnt_next = '0;
            hdr_next     = '0;
            crc_next     = CRC_SEED;
          end else if (rx_byte != SYNC_LO) begin
            phase_next = PH_SYNC0;
          end
        end
        PH_HDR: begin
          hdr_next[{hdr_cnt, 3'b000} +: 8] = rx_byte;
          crc_next     = crc_byte(crc, rx_byte);
          hdr_cnt_next = hdr_cnt + 3'd1;
          if (hdr_cnt == '0) begin
            // type byte: fetch its error count
            st_rd.en   = 1'b1;
            st_rd.addr = rx_byte;
          end
          if (hdr_cnt == HDR_LAST) begin
            if (len > 16'(MAX_PAYLOAD)) begin
              phase_next = PH_SYNC0;
            end else begin
              flen_next    = LEN_W'(len);
              pcnt_next    = '0;
              trl_cnt_next = 1'b0;
              phase_next   = (len == '0) ? PH_CRC : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          crc_next  = crc_byte(crc, rx_byte);
          pcnt_next = pcnt_inc;
          if (pcnt_inc >= flen) begin
            phase_next   = PH_CRC;
            trl_cnt_next = 1'b0;
          end
          res_new        = 1'b1;
          res.kind       = KIND_PAYLOAD;
          res.data_byte  = rx_byte;
          res.byte_index = pcnt16[9:0];
        end
        PH_CRC: begin
          if (!trl_cnt) begin
            trl_lo_next  = rx_byte;
            trl_cnt_next = 1'b1;
          end else begin
            trl_cnt_next = 1'b0;
            phase_next   = PH_SYNC0;
            res_new      = 1'b1;
            res.kind     = KIND_GOOD;
            res.received_crc = rx_crc;
            res.computed_crc = crc;
            if (rx_crc != crc) begin
              res.kind       = KIND_BAD;
              err_total_next = err_total + CNT_W'(1);
              type_cnt_next  = type_cnt + CNT_W'(1);
              st_wr.en       = 1'b1;
              st_wr.addr     = hdr[7:0];
              st_wr.data     = type_cnt + CNT_W'(1);
            end
          end
        end
        default: begin
          phase_next = PH_SYNC0;
        end
      endcase
    end

    res.frame_type       = hdr[7:0];
    res.frame_flags      = hdr[15:8];
    res.sequence_res     = hdr[47:32];
    res.payload_length   = flen16[10:0];
    res.total_crc_errors = err_total_next;
    res.type_crc_errors  = type_cnt_next;
  end

  // Output register with one-beat skid stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (skid_v) begin
        if (out_fire) begin
          skid_v <= 1'b0;
        end
      end else if (res_new) begin
        if (!out_v || out_fire) begin
          out_v <= 1'b1;
        end else begin
          skid_v <= 1'b1;
        end
      end else if (out_fire) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_fire) out_q <= skid_q;
    end else if (res_new) begin
      if (!out_v || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign res_valid        = out_v;
  assign kind             = out_q.kind;
  assign data_byte        = out_q.data_byte;
  assign byte_index       = out_q.byte_index;
  assign frame_type       = out_q.frame_type;
  assign frame_flags      = out_q.frame_flags;
  assign sequence_res     = out_q.sequence_res;
  assign payload_length   = out_q.payload_length;
  assign received_crc     = out_q.received_crc;
  assign computed_crc     = out_q.computed_crc;
  assign total_crc_errors = out_q.total_crc_errors;
  assign type_crc_errors  = out_q.type_crc_errors;

endmodule

// File: rtl/crcdf_checker.sv
// Port-level checks for crc16_frame_deframer, attached by bind.
// Depends on crcdf_pkg.
module crcdf_checker
  import crcdf_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_stall,
  input logic [1:0]       kind,
  input logic [7:0]       data_byte,
  input logic [9:0]       byte_index,
  input logic [15:0]      received_crc,
  input logic [15:0]      computed_crc,
  input logic [CNT_W-1:0] total_crc_errors
);

  // good frame end: trailer matches; bad: it does not
  a_good_crc: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_GOOD) |-> received_crc == computed_crc)
    else $error("good frame with CRC mismatch");

  a_bad_crc: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_BAD) |-> received_crc != computed_crc)
    else $error("bad frame with matching CRC");

  // payload beats carry no CRC, frame-end beats no byte
  a_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((kind == KIND_PAYLOAD) ? (received_crc == '0 && computed_crc == '0)
                                          : (data_byte == '0 && byte_index == '0)))
    else $error("field set does not match beat kind");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(kind) && $stable(total_crc_errors))
    else $error("stalled result changed");

endmodule

bind crc16_frame_deframer crcdf_checker u_crcdf_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res_valid),
  .res_stall        (res_stall),
  .kind             (kind),
  .data_byte        (data_byte),
  .byte_index       (byte_index),
  .received_crc     (received_crc),
  .computed_crc     (computed_crc),
  .total_crc_errors (total_crc_errors)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for crc16_frame_deframer. Byte beats go in and payload or frame-end beats
// come out. Depends on crcdf_pkg and the deframer RTL, and keeps its own parser and CRC-16.
module testbench;
  import crcdf_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 5;
  localparam int SMALL_ITEMS    = 1050;     // frame bytes to queue, at least, in all
  localparam int CYCLE_LIMIT    = 400000;
  localparam int TAIL_CYCLES    = 16;
  localparam int DRAIN_SPACING  = 400;
  localparam int HOLD_FOR_DRAIN = -1;       // link queue marker: sender waits for an empty scoreboard
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_LIGHT,
    FLOW_HEAVY,
    FLOW_PERIODIC
  } flow_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             rx_valid  = 1'b0;
  logic             rx_stall;
  logic [7:0]       rx_byte   = 8'h00;
  logic             res_valid;
  logic             res_stall = 1'b0;
  logic [1:0]       kind;
  logic [7:0]       data_byte;
  logic [9:0]       byte_index;
  logic [7:0]       frame_type;
  logic [7:0]       frame_flags;
  logic [15:0]      sequence_res;
  logic [10:0]      payload_length;
  logic [15:0]      received_crc;
  logic [15:0]      computed_crc;
  logic [CNT_W-1:0] total_crc_errors;
  logic [CNT_W-1:0] type_crc_errors;

  crc16_frame_deframer DUT (
    .clk              (clk),
    .rst              (rst),
    .rx_valid         (rx_valid),
    .rx_stall         (rx_stall),
    .rx_byte          (rx_byte),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .kind             (kind),
    .data_byte        (data_byte),
    .byte_index       (byte_index),
    .frame_type       (frame_type),
    .frame_flags      (frame_flags),
    .sequence_res     (sequence_res),
    .payload_length   (payload_length),
    .received_crc     (received_crc),
    .computed_crc     (computed_crc),
    .total_crc_errors (total_crc_errors),
    .type_crc_errors  (type_crc_errors)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------------
  // Parser model: same phases as the block, stepped once per accepted input beat.
  // ---------------------------------------------------------------------------------------------
  phase_t      rx_phase;
  logic [47:0] hdr_shift;
  int unsigned hdr_count;
  logic [10:0] frame_len;
  int unsigned pay_count;
  logic [7:0]  crc_low;
  logic        crc_half;
  logic [15:0] crc_acc;
  logic [31:0] bad_total;
  logic [31:0] bad_by_type [NUM_TYPES];

  res_t expected_q [$];     // result beats still owed by the block, oldest first
  int   link_q [$];         // bytes waiting to go on the link, plus drain markers

  int mismatches  = 0;
  int bytes_sent  = 0;
  int drains_done = 0;
  int n_payload   = 0;
  int n_good      = 0;
  int n_bad       = 0;

  // Bitwise reflected CRC-16, LSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
    return r;
  endfunction

  // Header-derived fields and error counts carried by every result beat; the rest stay zero.
  function automatic res_t frame_fields(input kind_t k);
    res_t r;
    r                  = '0;
    r.kind             = k;
    r.frame_type       = hdr_shift[7:0];
    r.frame_flags      = hdr_shift[15:8];
    r.sequence_res     = hdr_shift[47:32];
    r.payload_length   = frame_len;
    r.total_crc_errors = bad_total;
    r.type_crc_errors  = bad_by_type[hdr_shift[7:0]];
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    res_t        r;
    logic [15:0] len;
    logic [15:0] trailer;
    kind_t       k;
    case (rx_phase)
      PH_SYNC0: if (b == SYNC_LO) rx_phase = PH_SYNC1;
      PH_SYNC1: begin
        if (b == SYNC_HI) begin
          rx_phase  = PH_HDR;
          hdr_count = 0;
          hdr_shift = '0;
          crc_acc   = CRC_SEED;
        end else if (b != SYNC_LO) begin
          rx_phase = PH_SYNC0;
        end
      end
      PH_HDR: begin
        hdr_shift[8*hdr_count +: 8] = b;
        crc_acc   = crc16_step(crc_acc, b);
        hdr_count = hdr_count + 1;
        if (hdr_count == 6) begin
          len = hdr_shift[31:16];
          // oversized: back to hunting, nothing reported
          if (len > 16'(MAX_PAYLOAD_DEF)) begin
            rx_phase = PH_SYNC0;
          end else begin
            frame_len = len[10:0];
            pay_count = 0;
            crc_half  = 1'b0;
            rx_phase  = (len == 0) ? PH_CRC : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_acc      = crc16_step(crc_acc, b);
        r            = frame_fields(KIND_PAYLOAD);
        r.data_byte  = b;
        r.byte_index = pay_count[9:0];
        pay_count    = pay_count + 1;
        if (pay_count >= 32'(frame_len)) begin
          rx_phase = PH_CRC;
          crc_half = 1'b0;
        end
        expected_q.push_back(r);
      end
      PH_CRC: begin
        if (!crc_half) begin
          crc_low  = b;
          crc_half = 1'b1;
        end else begin
          trailer  = {b, crc_low};
          crc_half = 1'b0;
          rx_phase = PH_SYNC0;
          k        = KIND_GOOD;
          if (trailer != crc_acc) begin
            k         = KIND_BAD;
            bad_total = bad_total + 1;
            bad_by_type[hdr_shift[7:0]] = bad_by_type[hdr_shift[7:0]] + 1;
          end
          r              = frame_fields(k);
          r.received_crc = trailer;
          r.computed_crc = crc_acc;
          expected_q.push_back(r);
        end
      end
      default: rx_phase = PH_SYNC0;
    endcase
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Monitor: notes each accepted input beat and checks each accepted result beat.
  // ---------------------------------------------------------------------------------------------
  logic       in_taken = 1'b0;
  logic [7:0] in_data  = 8'h00;

  always @(posedge clk) begin : beat_monitor
    res_t want;
    in_taken <= !rst && rx_valid && !rx_stall;
    in_data  <= rx_byte;
    if (!rst && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", kind);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind",             32'(want.kind),             32'(kind));
        check_field("data_byte",        32'(want.data_byte),        32'(data_byte));
        check_field("byte_index",       32'(want.byte_index),       32'(byte_index));
        check_field("frame_type",       32'(want.frame_type),       32'(frame_type));
        check_field("frame_flags",      32'(want.frame_flags),      32'(frame_flags));
        check_field("sequence_res",     32'(want.sequence_res),     32'(sequence_res));
        check_field("payload_length",   32'(want.payload_length),   32'(payload_length));
        check_field("received_crc",     32'(want.received_crc),     32'(received_crc));
        check_field("computed_crc",     32'(want.computed_crc),     32'(computed_crc));
        check_field("total_crc_errors", want.total_crc_errors,      total_crc_errors);
        check_field("type_crc_errors",  want.type_crc_errors,       type_crc_errors);
        case (want.kind)
          KIND_PAYLOAD: n_payload++;
          KIND_GOOD:    n_good++;
          default:      n_bad++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Driver: steps the model for the beat just taken, then offers the next byte in bursts.
  // A drain marker holds the link idle until every owed result beat has been seen.
  // ---------------------------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin : link_driver
    if (in_taken) begin
      parse_byte(in_data);
      bytes_sent++;
    end
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || in_taken) begin
      if (link_q.size() != 0 && link_q[0] == HOLD_FOR_DRAIN) begin
        rx_valid <= 1'b0;
        if (expected_q.size() == 0) begin
          void'(link_q.pop_front());
          drains_done++;
        end
      end else if (gap_left != 0 || link_q.size() == 0) begin
        rx_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        rx_valid <= 1'b1;
        rx_byte  <= 8'(link_q.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // a zero gap merges bursts into long unbroken stretches
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Result side back-pressure: a mode held for a random spell, then redrawn.
  flow_t flow_mode = FLOW_FREE;
  int    flow_left = 0;
  int    flow_tick = 0;

  always @(negedge clk) begin : result_backpressure
    if (flow_left == 0) begin
      flow_mode = flow_t'($urandom_range(0, 3));
      flow_left = $urandom_range(40, 300);
    end else begin
      flow_left--;
    end
    flow_tick++;
    case (flow_mode)
      FLOW_FREE:  res_stall <= 1'b0;
      FLOW_LIGHT: res_stall <= ($urandom_range(0, 4) == 0);
      FLOW_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
      default:    res_stall <= ((flow_tick % 7) < 3);
    endcase
  end

  int unsigned cycle_count = 0;

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timed out with %0d result beats owed, %0d bytes queued",
             expected_q.size(), link_q.size());
      $display("FAIL crc16_frame_deframer");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------------
  int frame_items = 0;

  // Queues one framed message. An oversized length stops after the header, as the block
  // drops back to hunting there. A corrupt frame gets a non-zero error pattern on its CRC.
  task automatic push_frame(input logic [7:0] ftype, input logic [7:0] flags,
                            input logic [15:0] len, input logic [15:0] seq, input bit corrupt);
    logic [15:0] c;
    logic [7:0]  hdr [6];
    logic [7:0]  p;
    c   = CRC_SEED;
    hdr = '{ftype, flags, len[7:0], len[15:8], seq[7:0], seq[15:8]};
    link_q.push_back(int'(SYNC_LO));
    link_q.push_back(int'(SYNC_HI));
    foreach (hdr[i]) begin
      link_q.push_back(int'(hdr[i]));
      c = crc16_step(c, hdr[i]);
    end
    frame_items += 8;
    if (len <= 16'(MAX_PAYLOAD_DEF)) begin
      for (int i = 0; i < int'(len); i++) begin
        p = 8'($urandom);
        link_q.push_back(int'(p));
        c = crc16_step(c, p);
      end
      if (corrupt) c = c ^ 16'($urandom_range(1, 16'hFFFF));
      link_q.push_back(int'(c[7:0]));
      link_q.push_back(int'(c[15:8]));
      frame_items += int'(len) + 2;
    end
  endtask

  initial begin : stimulus
    int          pick;
    int          next_drain;
    logic [7:0]  ftype;
    logic [15:0] len;

    rx_phase  = PH_SYNC0;
    hdr_shift = '0;
    hdr_count = 0;
    frame_len = '0;
    pay_count = 0;
    crc_low   = '0;
    crc_half  = 1'b0;
    crc_acc   = CRC_SEED;
    bad_total = '0;
    foreach (bad_by_type[i]) bad_by_type[i] = '0;

    // Directed: an extra sync-low before the pair, an empty good frame with extreme header
    // bytes, an oversized header, then a one-byte payload with a bad CRC.
    link_q.push_back(int'(SYNC_LO));
    push_frame(8'hFF, 8'h00, 16'd0,      16'hFFFF, 1'b0);
    push_frame(8'h00, 8'hFF, 16'hFFFF,   16'h0000, 1'b0);
    push_frame(8'h80, 8'h5A, 16'd1,      16'h1234, 1'b1);
    link_q.push_back(HOLD_FOR_DRAIN);

    // Random: mostly well-formed frames, some noise, broken syncs and oversized headers.
    // A handful of frame types recur so that the per-type counts climb past one.
    next_drain = DRAIN_SPACING;
    while (frame_items < SMALL_ITEMS) begin
      pick  = $urandom_range(0, 99);
      ftype = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) link_q.push_back($urandom_range(0, 255));
      end else if (pick < 12) begin
        link_q.push_back(int'(SYNC_LO));
        link_q.push_back($urandom_range(0, 8'hA9));     // a value below the second sync byte 0xAA
      end else if (pick < 16) begin
        push_frame(ftype, 8'($urandom), 16'($urandom_range(MAX_PAYLOAD_DEF + 1, 16'hFFFF)),
                   16'($urandom), 1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      len = 16'($urandom_range(0, 8));
        else if (pick < 90) len = 16'($urandom_range(9, 40));
        else if (pick < 97) len = 16'($urandom_range(41, 150));
        else                len = 16'($urandom_range(151, 400));
        if ($urandom_range(0, 9) == 0) link_q.push_back(int'(SYNC_LO));
        push_frame(ftype, 8'($urandom), len, 16'($urandom), $urandom_range(0, 9) < 3);
      end
      if (frame_items >= next_drain) begin
        link_q.push_back(HOLD_FOR_DRAIN);
        next_drain += DRAIN_SPACING;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (link_q.size() != 0 || rx_valid || expected_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; checked %0d payload beats, %0d good and %0d CRC-rejected frames.",
             bytes_sent, n_payload, n_good, n_bad);
    $display("Sender held for %0d scoreboard drains; %0d field mismatches.",
             drains_done, mismatches);
    if (mismatches == 0) begin
      $display("PASS crc16_frame_deframer");
    end else begin
      $display("FAIL crc16_frame_deframer");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/crcdf_pkg.sv
rtl/crcdf_err_store.sv
rtl/crc16_frame_deframer.sv
rtl/crcdf_checker.sv
bench/testbench.sv
